// ===== rtl/usd_pkg.sv =====
// Package for the UTF-8 stream decoder: result-run descriptor and sequence state
// types, sequence-length and surrogate-range constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package usd_pkg;

    localparam int unsigned CpW   = 21;
    localparam int unsigned CntW  = 3;
    localparam int unsigned ByteW = 8;

    // Descriptor of the results caused by one input byte:
    // err_cnt errors first, then one optional tail result.
    typedef struct packed {
        logic [CntW-1:0] err_cnt;
        logic            has_tail;
        logic [CpW-1:0]  tail_cp;
        logic [CntW-1:0] tail_n;
    } t_run;

    // Sequence state carried between bytes.
    typedef struct packed {
        logic [CntW-1:0] seq_len;
        logic [CntW-1:0] held;
        logic [CpW-1:0]  partial;
    } t_seq;

    localparam logic [CntW-1:0] LenNone = 3'd0;
    localparam logic [CntW-1:0] LenOne  = 3'd1;
    localparam logic [CntW-1:0] LenTwo  = 3'd2;
    localparam logic [CntW-1:0] LenThr  = 3'd3;
    localparam logic [CntW-1:0] LenFour = 3'd4;

    localparam logic [CpW-1:0] SurLo = 21'h00D800;
    localparam logic [CpW-1:0] SurHi = 21'h00DFFF;

endpackage
`default_nettype wire

// ===== rtl/utf8_stream_decoder.sv =====
// UTF-8 stream decoder top level: input register, decode, result emitter.
// Depends on usd_pkg, usd_decode, usd_emit.
// A byte passes the input register, then is decoded and loaded into the emitter register.
// One byte per cycle while the emitter is free; a byte causing k results holds input until its last result is taken.
// Bytes that open or extend a sequence cause no result and are not loaded into the emitter.
// Reset (synchronous, active low) closes any open sequence and empties both registers.
`timescale 1ns / 1ps
`default_nettype none
module utf8_stream_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic        i_s_tlast,   // end_of_buffer
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // [20:0] code_point, [23:21] byte_count
    output logic [0:0]       o_m_tuser,   // [0] is_error
    output logic             o_m_tlast    // last_of_run
);

    logic          r_in_valid;
    logic [7:0]    r_byte;
    logic          r_eob;
    logic          w_free;
    logic          w_advance;
    logic          w_nonempty;
    usd_pkg::t_run w_run;

    assign w_advance  = r_in_valid && w_free;
    assign o_s_tready = !r_in_valid || w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_byte <= i_s_tdata;
            r_eob  <= i_s_tlast;
        end
    end

    usd_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (w_advance),
        .i_byte         (r_byte),
        .i_eob          (r_eob),
        .o_run          (w_run),
        .o_run_nonempty (w_nonempty)
    );

    usd_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_advance && w_nonempty),
        .i_run      (w_run),
        .o_free     (w_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule
`default_nettype wire

// ===== rtl/usd_decode.sv =====
// Sequence state registers and single-byte decode logic.
// Produces one result-run descriptor per byte; uses usd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module usd_decode (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_advance,
    input  wire logic [7:0]              i_byte,
    input  wire logic                    i_eob,
    output usd_pkg::t_run                o_run,
    output logic                         o_run_nonempty
);

    usd_pkg::t_seq r_seq;
    usd_pkg::t_seq n_seq;
    usd_pkg::t_run w_run;

    logic                           w_f_ascii;
    logic                           w_f_lead;
    logic [usd_pkg::CntW-1:0]       w_f_len;
    logic [usd_pkg::CpW-1:0]        w_f_bits;
    logic [usd_pkg::CpW-1:0]        w_acc;
    logic [usd_pkg::CntW-1:0]       w_held_inc;

    // Lead-byte classification
    always_comb begin
        w_f_ascii = 1'b0;
        w_f_lead  = 1'b0;
        w_f_len   = usd_pkg::LenNone;
        w_f_bits  = '0;
        case (i_byte) inside
            [8'h00:8'h7F]: begin
                w_f_ascii = 1'b1;
            end
            [8'hC0:8'hDF]: begin
                w_f_lead = 1'b1;
                w_f_len  = usd_pkg::LenTwo;
                w_f_bits = {16'd0, i_byte[4:0]};
            end
            [8'hE0:8'hEF]: begin
                w_f_lead = 1'b1;
                w_f_len  = usd_pkg::LenThr;
                w_f_bits = {17'd0, i_byte[3:0]};
            end
            [8'hF0:8'hF7]: begin
                w_f_lead = 1'b1;
                w_f_len  = usd_pkg::LenFour;
                w_f_bits = {18'd0, i_byte[2:0]};
            end
            default: begin
            end
        endcase
    end

    assign w_acc      = {r_seq.partial[14:0], i_byte[5:0]};
    assign w_held_inc = r_seq.held + 3'd1;

    always_comb begin
        n_seq          = r_seq;
        w_run.err_cnt  = '0;
        w_run.has_tail = 1'b0;
        w_run.tail_cp  = '0;
        w_run.tail_n   = usd_pkg::LenOne;
        if (r_seq.seq_len != usd_pkg::LenNone && i_byte[7:6] == 2'b10) begin
            if (w_held_inc >= r_seq.seq_len) begin
                n_seq = '0;
                if (w_acc >= usd_pkg::SurLo && w_acc <= usd_pkg::SurHi) begin
                    w_run.err_cnt = r_seq.seq_len;
                end else begin
                    w_run.has_tail = 1'b1;
                    w_run.tail_cp  = w_acc;
                    w_run.tail_n   = r_seq.seq_len;
                end
            end else if (i_eob) begin
                n_seq         = '0;
                w_run.err_cnt = w_held_inc;
            end else begin
                n_seq.held    = w_held_inc;
                n_seq.partial = w_acc;
            end
        end else begin
            // bad continuation flushes held bytes, then byte decoded afresh
            w_run.err_cnt = r_seq.held;
            n_seq         = '0;
            if (w_f_ascii) begin
                w_run.has_tail = 1'b1;
                w_run.tail_cp  = {13'd0, i_byte};
            end else if (w_f_lead && !i_eob) begin
                n_seq.seq_len = w_f_len;
                n_seq.held    = usd_pkg::LenOne;
                n_seq.partial = w_f_bits;
            end else begin
                w_run.err_cnt = r_seq.held + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
        end else if (i_advance) begin
            r_seq <= n_seq;
        end
    end

    assign o_run          = w_run;
    assign o_run_nonempty = (w_run.err_cnt != '0) || w_run.has_tail;

    a_closed_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq.seq_len == usd_pkg::LenNone |-> r_seq.held == '0 && r_seq.partial == '0)
        else $error("closed sequence holds data");
    a_open_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq.seq_len != usd_pkg::LenNone |->
            r_seq.held != '0 && r_seq.held < r_seq.seq_len)
        else $error("held count out of range");
    a_len_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq.seq_len == usd_pkg::LenNone || r_seq.seq_len == usd_pkg::LenTwo ||
        r_seq.seq_len == usd_pkg::LenThr || r_seq.seq_len == usd_pkg::LenFour)
        else $error("illegal sequence length");

endmodule
`default_nettype wire

// ===== rtl/usd_emit.sv =====
// Result-run register: emits the errors and optional tail of one byte,
// one result per transfer. Uses usd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module usd_emit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  wire usd_pkg::t_run  i_run,
    output logic                o_free,
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    output logic [23:0]         o_m_tdata,
    output logic [0:0]          o_m_tuser,
    output logic                o_m_tlast
);

    logic                     r_valid;
    logic [usd_pkg::CntW-1:0] r_err_left;
    logic                     r_has_tail;
    logic [usd_pkg::CpW-1:0]  r_cp;
    logic [usd_pkg::CntW-1:0] r_n;

    logic w_is_err;
    logic w_last;
    logic w_xfer;

    assign w_is_err = (r_err_left != '0);
    assign w_last   = w_is_err ? (r_err_left == 3'd1 && !r_has_tail) : 1'b1;
    assign w_xfer   = r_valid && i_m_tready;
    assign o_free   = !r_valid || (w_xfer && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_err_left <= '0;
            r_has_tail <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
            if (i_load) begin
                r_err_left <= i_run.err_cnt;
                r_has_tail <= i_run.has_tail;
            end
        end else if (w_xfer && w_is_err) begin
            r_err_left <= r_err_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_cp <= i_run.tail_cp;
            r_n  <= i_run.tail_n;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = w_is_err ? {usd_pkg::LenOne, 21'd0} : {r_n, r_cp};
    assign o_m_tuser  = w_is_err;
    assign o_m_tlast  = w_last;

    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_err_left == '0 |-> r_has_tail)
        else $error("empty result run held");
    a_err_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_err_left <= 3'd4)
        else $error("too many errors in run");
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_xfer && !w_last |=> r_valid)
        else $error("run dropped before its last result");

endmodule
`default_nettype wire
